[sv/mhpq_pkg.sv]
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY_DEF = 8;

  localparam logic [7:0] EMPTY_STAGE = 8'd32;
  localparam logic [16:0] NONE_FIELD = 17'h1FFFF;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  stage;
    logic [15:0] prio;
    logic [15:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[sv/mhpq_ram.sv]
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[sv/max_heap_priority_queue.sv]
`default_nettype none
// Load without build: entry written at the live count, then the result is pushed.
// Extract: read root and last entry, then at most log2 CAPACITY sift levels, one per
//   cycle from registered reads of both children; none for the last entry or when empty.
// Build on last load: each parent, last one back to the root, is read and sifted down.
// One item in flight: input reopens once the output register is loaded.
// Reset (rst_n low, synchronous): heap empty, no result pending; memory is not cleared.

module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] entry_id, [31:16] priority_req, [39:32] stage_code
  input  wire logic [39:0] in_tdata,
  // [0] cmd
  input  wire logic        in_tuser,
  // last_load
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [16:0] out_id, [33:17] out_priority, [41:34] out_stage, [47:42] zero
  output logic      [47:0] out_tdata,
  // [1:0] status
  output logic      [1:0]  out_tuser
);

  import mhpq_pkg::*;

  localparam int PW = $clog2(CAPACITY);     // heap position
  localparam int CW = $clog2(CAPACITY + 1); // live count
  localparam int XW = PW + 2;               // child index, may run past the end

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_RD,
    S_EXT_RD,
    S_SIFT_RD,
    S_SIFT,
    S_PUSH
  } state_t;

  state_t        state_r;
  logic [CW-1:0] live_count_r;
  logic          build_r;
  logic [PW-1:0] i_r;
  logic [PW-1:0] pos_r;
  entry_t        cur_r;

  logic [1:0]         res_status_r;
  logic signed [16:0] res_id_r;
  logic signed [16:0] res_prio_r;
  logic [7:0]         res_stage_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [16:0] out_id_r;
  logic signed [16:0] out_prio_r;
  logic [7:0]         out_stage_r;

  // RAM ports
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [PW-1:0] ram_raddr_a;
  logic [PW-1:0] ram_raddr_b;
  entry_t        rd_a;
  entry_t        rd_b;

  mhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Input transfer decode
  logic   in_xfer;
  cmd_t   in_cmd;
  entry_t in_entry;
  logic   has_room;
  logic [CW-1:0] cnt_after_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_entry.id    = in_tdata[15:0];
  assign in_entry.prio  = in_tdata[31:16];
  assign in_entry.stage = in_tdata[39:32];
  assign has_room  = (live_count_r < CW'(CAPACITY));
  assign cnt_after_load = has_room ? live_count_r + 1'b1 : live_count_r;

  // Sift step: compare the moving entry against both children of pos_r.
  // Children that fall past the live count take no part.
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic          take_l;
  logic          take_r;
  logic [15:0]   best_prio;
  logic          swap;
  logic [XW-1:0] best_x;
  entry_t        best_ent;
  logic [PW-1:0] rd_pos;
  logic [XW-1:0] rd_left_x;
  logic [XW-1:0] rd_right_x;

  assign cnt_x     = XW'(live_count_r);
  assign left_x    = {1'b0, pos_r, 1'b1};
  assign right_x   = left_x + 1'b1;
  assign take_l    = (left_x < cnt_x) && (rd_a.prio > cur_r.prio);
  assign best_prio = take_l ? rd_a.prio : cur_r.prio;
  assign take_r    = (right_x < cnt_x) && (rd_b.prio > best_prio);
  assign swap      = take_l || take_r;
  assign best_x    = take_r ? right_x : left_x;
  assign best_ent  = take_r ? rd_b : rd_a;

  // Fetch the children of the next position ahead of time: one level per cycle.
  assign rd_pos     = (state_r == S_SIFT) ? best_x[PW-1:0] : pos_r;
  assign rd_left_x  = {1'b0, rd_pos, 1'b1};
  assign rd_right_x = rd_left_x + 1'b1;

  always_comb begin
    ram_raddr_a = rd_left_x[PW-1:0];
    ram_raddr_b = rd_right_x[PW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = swap ? best_ent : cur_r;
    unique case (state_r)
      S_IDLE: begin
        // append a loaded entry at the live count
        ram_we    = in_xfer && (in_cmd == CMD_LOAD) && has_room;
        ram_waddr = live_count_r[PW-1:0];
        ram_wdata = in_entry;
      end
      S_BLD_RD: begin
        ram_raddr_a = i_r;
      end
      S_EXT_RD: begin
        ram_raddr_a = '0;
        ram_raddr_b = PW'(live_count_r - 1'b1);
      end
      S_SIFT: begin
        // move the larger child up, or drop the moving entry into the hole
        ram_we = 1'b1;
      end
      S_SIFT_RD, S_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      live_count_r <= '0;
      build_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop a taken result unless a new one is loaded in the same cycle
      if (out_valid_r && out_tready && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            res_id_r    <= NONE_FIELD;
            res_prio_r  <= NONE_FIELD;
            res_stage_r <= EMPTY_STAGE;
            if (in_cmd == CMD_LOAD) begin
              live_count_r <= cnt_after_load;
              res_status_r <= has_room ? ST_OK : ST_FULL;
              if (in_tlast && (cnt_after_load >= CW'(2))) begin
                build_r <= 1'b1;
                i_r     <= PW'((cnt_after_load - CW'(2)) >> 1);
                state_r <= S_BLD_RD;
              end else begin
                state_r <= S_PUSH;
              end
            end else if (live_count_r == '0) begin
              res_status_r <= ST_EMPTY;
              state_r      <= S_PUSH;
            end else begin
              res_status_r <= ST_OK;
              build_r      <= 1'b0;
              state_r      <= S_EXT_RD;
            end
          end
        end
        S_BLD_RD: begin
          pos_r   <= i_r;
          state_r <= S_SIFT_RD;
        end
        S_EXT_RD: begin
          pos_r   <= '0;
          state_r <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          if (build_r) begin
            cur_r   <= rd_a;
            state_r <= S_SIFT;
          end else begin
            // hand out the root, move the last live entry to the top
            res_id_r     <= {1'b0, rd_a.id};
            res_prio_r   <= {1'b0, rd_a.prio};
            res_stage_r  <= rd_a.stage;
            cur_r        <= rd_b;
            live_count_r <= live_count_r - 1'b1;
            state_r      <= (live_count_r == CW'(1)) ? S_PUSH : S_SIFT;
          end
        end
        S_SIFT: begin
          if (swap) begin
            pos_r <= best_x[PW-1:0];
          end else if (build_r && (i_r != '0)) begin
            i_r     <= i_r - 1'b1;
            state_r <= S_BLD_RD;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_prio_r   <= res_prio_r;
            out_stage_r  <= res_stage_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_stage_r, out_prio_r, out_id_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= CW'(CAPACITY))
    else $error("live count beyond capacity");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIFT) |-> (XW'(pos_r) < cnt_x))
    else $error("sift position outside live entries");

  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_cmd == CMD_LOAD) && has_room)
      |=> (live_count_r == $past(live_count_r) + 1'b1))
    else $error("accepted load did not grow the heap");

  a_extract_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_cmd == CMD_EXTRACT) && (live_count_r != '0)) |=> (state_r == S_EXT_RD))
    else $error("extract from non-empty heap did not start a read");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_valid_r && !out_tready) |=> (state_r == S_PUSH))
    else $error("result overwrote a pending output");
`endif

endmodule

`default_nettype wire

[tb/sv/max_heap_priority_queue_tb.sv]
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int TOTAL_ITEMS = 1950;
  localparam int IDLE_PCT    = 27;
  // Receiver hold-off, long enough to back the queue up into the input side.
  localparam int HOLD_CYCLES = 400;
  // Cycles with no transfer on either side before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Drain time after the last result: longer than the slowest heap build.
  localparam int END_GAP     = 60;
  localparam int REPORT_MAX  = 10;

  // One result as seen on the output side, fields split out of tdata/tuser.
  typedef struct packed {
    status_t     status;
    logic [16:0] id;
    logic [16:0] prio;
    logic [7:0]  stage;
  } heap_result_t;

  localparam heap_result_t RES_LOADED = '{ST_OK, NONE_FIELD, NONE_FIELD, EMPTY_STAGE};
  localparam heap_result_t RES_FULL   = '{ST_FULL, NONE_FIELD, NONE_FIELD, EMPTY_STAGE};
  localparam heap_result_t RES_EMPTY  = '{ST_EMPTY, NONE_FIELD, NONE_FIELD, EMPTY_STAGE};
  localparam heap_result_t RES_TOP    = '{ST_OK, 17'h0FFFF, 17'h0FFFF, 8'hFF};

  // Directed row: command, entry {stage, prio, id}, build flag, and a
  // hand-written expectation where the answer is obvious (typed = 1).
  typedef struct {
    cmd_t         op;
    entry_t       ent;
    bit           build;
    bit           typed;
    heap_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // extract straight after reset: nothing stored yet
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b1, RES_EMPTY},
    // fill to capacity: all-zero entry, all-ones entry, ties on 0x8000
    '{CMD_LOAD,    {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h55, 16'h8000, 16'h1234}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h01, 16'h7FFF, 16'h0001}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h80, 16'h8000, 16'h0002}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h7F, 16'h0001, 16'h0003}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'hAA, 16'hFFFE, 16'h0004}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h5A, 16'h8000, 16'h0005}, 1'b1, 1'b1, RES_LOADED},
    // loads into a full heap are refused; the second still rebuilds
    '{CMD_LOAD,    {8'h44, 16'h4444, 16'hBEEF}, 1'b0, 1'b1, RES_FULL},
    '{CMD_LOAD,    {8'h99, 16'h9999, 16'hCAFE}, 1'b1, 1'b1, RES_FULL},
    // the all-ones key is the unique maximum
    '{CMD_EXTRACT, {8'h12, 16'h3456, 16'h789A}, 1'b1, 1'b1, RES_TOP},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    '{CMD_EXTRACT, {8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0, '0},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    // drained again
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b1, RES_EMPTY},
    // root smaller than two equal children: the left child must rise
    '{CMD_LOAD,    {8'h20, 16'h0064, 16'h0020}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h21, 16'h012C, 16'h0021}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_LOAD,    {8'h22, 16'h012C, 16'h0022}, 1'b1, 1'b1, RES_LOADED},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
    // append without a build, then extract from the unordered array
    '{CMD_LOAD,    {8'h30, 16'hF000, 16'h0030}, 1'b0, 1'b1, RES_LOADED},
    '{CMD_EXTRACT, {8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shared between stimulus and receiver: calm switches idling off on both
  // sides, drain_hold asks the receiver for one long hold-off.
  bit calm       = 1'b0;
  bit drain_hold = 1'b0;

  int items_sent   = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;

  heap_result_t expected_results [$];

  // Heap image kept by the predictor.
  entry_t      pq_slots [CAPACITY];
  int unsigned pq_count = 0;

  max_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Push a node down while a child holds a strictly larger key; on equal
  // children the left one is taken because the right must beat the best so far.
  function automatic void heap_sift(input int unsigned start);
    int unsigned pos;
    int unsigned best;
    int unsigned lch;
    int unsigned rch;
    entry_t      tmp;
    bit          done;
    pos  = start;
    done = 1'b0;
    while (!done) begin
      best = pos;
      lch  = 2 * pos + 1;
      rch  = 2 * pos + 2;
      if (lch < pq_count && pq_slots[lch].prio > pq_slots[best].prio) best = lch;
      if (rch < pq_count && pq_slots[rch].prio > pq_slots[best].prio) best = rch;
      if (best == pos) begin
        done = 1'b1;
      end else begin
        tmp            = pq_slots[pos];
        pq_slots[pos]  = pq_slots[best];
        pq_slots[best] = tmp;
        pos            = best;
      end
    end
  endfunction

  // Bottom-up build: every parent from the last one back to the root.
  function automatic void heap_build();
    if (pq_count >= 2) begin
      for (int i = int'(pq_count / 2) - 1; i >= 0; i--) heap_sift(i);
    end
  endfunction

  // Advance the heap image by one command and return the result it yields.
  function automatic heap_result_t heap_predict(input cmd_t op, input entry_t ent,
                                                input bit build);
    heap_result_t r;
    entry_t       top;
    r = RES_LOADED;
    if (op == CMD_LOAD) begin
      if (pq_count < CAPACITY) begin
        pq_slots[pq_count] = ent;
        pq_count++;
      end else begin
        r.status = ST_FULL;
      end
      if (build) heap_build();
    end else if (pq_count == 0) begin
      r = RES_EMPTY;
    end else begin
      // swap root into the hidden slot, shrink, restore from the root
      top                = pq_slots[0];
      pq_count--;
      pq_slots[0]        = pq_slots[pq_count];
      pq_slots[pq_count] = top;
      heap_sift(0);
      r = '{ST_OK, {1'b0, top.id}, {1'b0, top.prio}, top.stage};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one item from the falling edge, idling first at random, and hold it
  // until a rising edge sees tready. The expectation is queued on acceptance.
  task automatic send_item(input cmd_t op, input entry_t ent, input bit build,
                           input bit typed, input heap_result_t typed_res);
    heap_result_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ent;
    in_tlast  <= build;
    do @(posedge clk); while (!in_tready);
    predicted = heap_predict(op, ent, build);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Withdraw the last offer, then hold until every expected result is back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random entry; a narrow key range forces plenty of equal priorities.
  function automatic entry_t rand_entry(input bit narrow);
    entry_t e;
    e.id    = 16'($urandom);
    e.stage = 8'($urandom);
    if (narrow)                          e.prio = 16'($urandom_range(0, 3));
    else if ($urandom_range(0, 15) == 0) e.prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else                                 e.prio = 16'($urandom);
    return e;
  endfunction

  // Extract with junk in the ignored fields.
  task automatic send_extract();
    send_item(CMD_EXTRACT, rand_entry(1'b0), 1'($urandom), 1'b0, '0);
  endtask

  initial begin : stimulus
    int     n;
    int     kind;
    int     next_pause;
    bit     narrow;
    bit     calm_done;
    bit     hold_done;

    next_pause = 300;
    calm_done  = 1'b0;
    hold_done  = 1'b0;

    // hold reset low, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].op, dir_tab[i].ent, dir_tab[i].build,
                dir_tab[i].typed, dir_tab[i].res);
    end
    wait_drained();

    // random part
    while (items_sent < TOTAL_ITEMS) begin
      // sender pause until every result is back
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause += 1200;
      end
      // long stretch with no idling on either side
      if (!calm_done && items_sent >= 600) begin
        calm      = 1'b1;
        calm_done = 1'b1;
      end
      if (calm && items_sent >= 900) calm = 1'b0;
      // receiver holds off while items keep coming
      if (!hold_done && items_sent >= 1100) begin
        drain_hold = 1'b1;
        hold_done  = 1'b1;
      end

      kind   = $urandom_range(0, 99);
      narrow = ($urandom_range(0, 99) < 30);
      if (kind < 68) begin
        // well-formed: load a batch, build on the final load, drain it
        n = $urandom_range(1, CAPACITY);
        for (int j = 0; j < n; j++) send_item(CMD_LOAD, rand_entry(narrow), j == n - 1, 1'b0, '0);
        n += $urandom_range(0, 1);
        repeat (n) send_extract();
      end else if (kind < 80) begin
        // overfill: loads past capacity, builds scattered in
        n = CAPACITY + $urandom_range(1, 3);
        for (int j = 0; j < n; j++) begin
          send_item(CMD_LOAD, rand_entry(narrow),
                    (j == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
        end
        repeat (CAPACITY + 1) send_extract();
      end else if (kind < 90) begin
        // appends without a build, then extract from the unordered slots
        n = $urandom_range(1, 4);
        repeat (n) send_item(CMD_LOAD, rand_entry(narrow), 1'b0, 1'b0, '0);
        repeat ($urandom_range(1, n + 1)) send_extract();
      end else begin
        // noise: fully random items
        repeat ($urandom_range(1, 6)) begin
          send_item($urandom_range(0, 1) ? CMD_EXTRACT : CMD_LOAD, rand_entry(narrow),
                    1'($urandom), 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (END_GAP) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (drain_hold) begin
        drain_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each transfer out against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    heap_result_t got;
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status_t'(out_tuser), out_tdata[16:0], out_tdata[33:17], out_tdata[41:34]};
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
          $display("unexpected result %0d: st=%0d id=%h prio=%h stage=%h", results_seen,
                   got.status, got.id, got.prio, got.stage);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.id !== want.id ||
            got.prio !== want.prio || got.stage !== want.stage) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("mismatch at result %0d: expected st=%0d id=%h prio=%h stage=%h",
                     results_seen, want.status, want.id, want.prio, want.stage);
            $display("  got st=%0d id=%h prio=%h stage=%h",
                     got.status, got.id, got.prio, got.stage);
          end
        end
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: abandon the run after a long spell with no transfer at all
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
